/* rtl/core/acbf_pkg.sv */
// ----------------------------------------------------------------------------
// acbf_pkg
// Shared types, constants and helpers of the alignment column unique base
// finder.
// ----------------------------------------------------------------------------
package acbf_pkg;

  localparam int NSeq    = 8;
  localparam int LaneW   = (NSeq > 1) ? $clog2(NSeq) : 1;
  localparam int QDepth  = 4;
  localparam int QPtrW   = $clog2(QDepth);
  localparam int QCntW   = $clog2(QDepth + 1);
  localparam int CfgIdxW = 4;

  localparam logic [7:0] GapByte = 8'h2D;
  localparam int NumAmbig = 11;
  localparam logic [NumAmbig-1:0][7:0] AmbigCodes = {
    8'h59, 8'h52, 8'h57, 8'h53, 8'h4B, 8'h4D, 8'h44, 8'h56, 8'h48, 8'h42, 8'h4E
  };

  // One usable column: unique-base lanes and column minus gaps per lane
  typedef struct packed {
    logic [NSeq-1:0]       uniq;
    logic [NSeq-1:0][31:0] diff;
  } col_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_status_t;

  typedef struct packed {
    logic               valid;
    logic [CfgIdxW-1:0] index;
    logic [31:0]        data;
  } cfg_write_t;

  function automatic logic is_bad(input logic [7:0] b);
    logic bad;
    bad = (b == GapByte);
    for (int t = 0; t < NumAmbig; t++) begin
      if (b == AmbigCodes[t]) bad = 1'b1;
    end
    return bad;
  endfunction

endpackage

/* rtl/core/acbf_front.sv */
// ----------------------------------------------------------------------------
// acbf_front
// Accepts columns, keeps the gap and column counters and classifies each
// column into a queue entry.
// ----------------------------------------------------------------------------
module acbf_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [63:0]            s_tdata,   // column_bases
  input  acbf_pkg::fifo_status_t qstat,
  output logic                   push,
  output acbf_pkg::col_entry_t   push_entry
);

  logic [31:0]                 column_count;
  logic [acbf_pkg::NSeq-1:0][31:0] gap_count;
  logic [acbf_pkg::NSeq-1:0][7:0]  b;
  logic                        bad;
  logic                        take;

  assign s_tready = !qstat.full;
  assign take     = s_tvalid && s_tready;

  always_comb begin
    bad = 1'b0;
    for (int k = 0; k < acbf_pkg::NSeq; k++) begin
      b[k] = s_tdata[8*k +: 8];
      if (acbf_pkg::is_bad(b[k])) bad = 1'b1;
    end
    for (int k = 0; k < acbf_pkg::NSeq; k++) begin
      push_entry.uniq[k] = 1'b1;
      for (int m = 0; m < acbf_pkg::NSeq; m++) begin
        if (m != k && b[m] == b[k]) push_entry.uniq[k] = 1'b0;
      end
      push_entry.diff[k] = column_count - gap_count[k];
    end
  end

  assign push = take && !bad && (|push_entry.uniq);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= 32'd1;
      gap_count    <= '0;
    end else if (take) begin
      column_count <= column_count + 32'd1;
      for (int k = 0; k < acbf_pkg::NSeq; k++) begin
        if (b[k] == acbf_pkg::GapByte) gap_count[k] <= gap_count[k] + 32'd1;
      end
    end
  end

endmodule

/* rtl/core/acbf_fifo.sv */
// ----------------------------------------------------------------------------
// acbf_fifo
// Short queue of classified columns between front and back.
// ----------------------------------------------------------------------------
module acbf_fifo (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  acbf_pkg::col_entry_t   push_entry,
  input  logic                   pop,
  output acbf_pkg::col_entry_t   head,
  output acbf_pkg::fifo_status_t qstat
);

  acbf_pkg::col_entry_t           mem [acbf_pkg::QDepth];
  logic [acbf_pkg::QPtrW-1:0]     wr_ptr;
  logic [acbf_pkg::QPtrW-1:0]     rd_ptr;
  logic [acbf_pkg::QCntW-1:0]     count;
  logic                           do_push;
  logic                           do_pop;

  assign qstat.empty = (count == '0);
  assign qstat.full  = (count == acbf_pkg::QCntW'(acbf_pkg::QDepth));
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign head        = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule

/* rtl/core/acbf_back.sv */
// ----------------------------------------------------------------------------
// acbf_back
// Walks the unique lanes of each queued column and emits one result request
// per cycle into the output register unless m_tready stalls it. Holds the start offsets.
// ----------------------------------------------------------------------------
module acbf_back (
  input  logic                   clk,
  input  logic                   rst,
  input  acbf_pkg::cfg_write_t   cfg,
  input  acbf_pkg::col_entry_t   head,
  input  acbf_pkg::fifo_status_t qstat,
  output logic                   pop,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [71:0]            m_tdata,   // seq_index, contig_coord, master_coord, zero fill
  output logic                   m_tlast    // last_of_column
);

  logic [acbf_pkg::NSeq-1:0][31:0] start_offset;
  logic                        work_valid;
  acbf_pkg::col_entry_t        work;
  logic [acbf_pkg::LaneW-1:0]  sel;
  logic [acbf_pkg::NSeq-1:0]   rest;
  logic                        load_en;
  logic                        emit;
  logic [32:0]                 contig;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < acbf_pkg::NSeq; k++) start_offset[k] <= 32'd1;
    end else if (cfg.valid) begin
      for (int k = 0; k < acbf_pkg::NSeq; k++) begin
        if (cfg.index == acbf_pkg::CfgIdxW'(k)) start_offset[k] <= cfg.data;
      end
    end
  end

  always_comb begin
    sel = '0;
    for (int k = acbf_pkg::NSeq - 1; k >= 0; k--) begin
      if (work.uniq[k]) sel = acbf_pkg::LaneW'(k);
    end
    rest      = work.uniq;
    rest[sel] = 1'b0;
  end

  assign load_en = !m_tvalid || m_tready;
  assign emit    = work_valid && load_en;
  assign pop     = !qstat.empty && (!work_valid || (emit && rest == '0));
  // diff + offset - 1, modulo 2^33
  assign contig  = {1'b0, work.diff[sel]} + {1'b0, start_offset[sel]} + {33{1'b1}};

  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid <= 1'b0;
    end else if (pop) begin
      work_valid <= 1'b1;
    end else if (emit) begin
      work_valid <= (rest != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      work <= head;
    end else if (emit) begin
      work.uniq <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_en) begin
      m_tvalid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= {4'b0, work.diff[0], contig, 3'(sel)};
      m_tlast <= (rest == '0);
    end
  end

endmodule

/* rtl/core/alignment_column_unique_base_finder_top.sv */
// ----------------------------------------------------------------------------
// alignment_column_unique_base_finder_top
// Finds the bases that occur once in a usable alignment column.
//
// Columns enter on the s_t* channel, one byte per sequence. A column holding
// a gap or an ambiguity code is dropped; the gap and column counters advance
// on every accepted column. For a usable column, one request leaves on the
// m_t* channel for each sequence with a unique base, lowest sequence first,
// m_tlast on the final one of the column.
// The first result of a column passes through the column queue, the work
// register and the output register. Throughput: one column per cycle while
// each column yields at most one result and m_tready does not stall; a column
// with several results holds the result sequencer until each is emitted, and
// the four-entry column queue absorbs bursts before s_tready drops. A stalled
// m_tready holds the output register and backs up through the queue to the input.
// Start offsets are written on the cfg_* channel (index k for sequence k,
// always ready). Reset clears the counters, sets column count and start
// offsets to one and empties the queue and output register.
// ----------------------------------------------------------------------------
module alignment_column_unique_base_finder_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [63:0]                  s_tdata,    // column_bases
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [71:0]                  m_tdata,    // seq_index, contig_coord, master_coord
  output logic                         m_tlast,    // last_of_column
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [acbf_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [31:0]                  cfg_data
);

  acbf_pkg::fifo_status_t qstat;
  acbf_pkg::col_entry_t   push_entry;
  acbf_pkg::col_entry_t   head;
  acbf_pkg::cfg_write_t   cfg;
  logic                   push;
  logic                   pop;

  assign cfg_ready = 1'b1;
  assign cfg.valid = cfg_valid;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  acbf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .qstat      (qstat),
    .push       (push),
    .push_entry (push_entry)
  );

  acbf_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .qstat      (qstat)
  );

  acbf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .head     (head),
    .qstat    (qstat),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
